[rtl/qrs_pkg.sv]
// Package for the quadratic root solver: widths, result status codes and
// the beat types that travel down the square-root and divider cell rows.
// No dependencies.
package qrs_pkg;

  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 16;
  localparam int ROOT_W    = 34;

  localparam int PROD_W = 2 * COEF_W;       // b*b and a*c
  localparam int DISC_W = PROD_W + 3;       // signed b*b - 4ac
  localparam int D_W    = PROD_W + 2;       // positive discriminant bits
  localparam int SQ_W   = D_W / 2;          // integer square root
  localparam int SQR_W  = SQ_W + 4;         // square-root remainder
  localparam int DEN_W  = COEF_W + 1;       // |2a|
  localparam int T_W    = SQ_W + 2;         // signed -b +/- s
  localparam int NUM_W  = T_W - 1 + FRAC_BITS;  // numerator magnitude
  localparam int DR_W   = DEN_W + 1;        // divider remainder

  typedef enum logic [1:0] {
    ST_TWO     = 2'd0,
    ST_DOUBLE  = 2'd1,
    ST_IMAG    = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef struct packed {
    status_t                  status;
    logic signed [COEF_W:0]   neg_b;
    logic [DEN_W-1:0]         den_mag;
    logic                     den_neg;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [SQR_W-1:0]  rem;
    logic [SQ_W-1:0]   root;
    logic [D_W-1:0]    dsh;
  } sq_t;

  // Both roots share one divisor, so one divider cell carries two lanes.
  typedef struct packed {
    status_t                 status;
    logic [DEN_W-1:0]        den_mag;
    logic [1:0]              neg;
    logic [1:0][DR_W-1:0]    rem;
    logic [1:0][NUM_W-1:0]   n;
    logic [1:0][NUM_W-1:0]   q;
  } dv_t;

endpackage

[rtl/qrs_if.sv]
// Channel interfaces of the quadratic root solver: coefficient beats in,
// result beats out. Depends on qrs_pkg.
interface qrs_in_if
  import qrs_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] coef_a;
  logic signed [COEF_W-1:0] coef_b;
  logic signed [COEF_W-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_out_if
  import qrs_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [1:0]               root_status;
  logic signed [ROOT_W-1:0] root_one;
  logic signed [ROOT_W-1:0] root_two;

  modport source (output valid, root_status, root_one, root_two, input ready);
  modport sink   (input valid, root_status, root_one, root_two, output ready);
endinterface

[rtl/qrs_sqrt_cell.sv]
// One cell of the square-root row: resolves one root bit per cycle, while its
// enable is high, from two discriminant bits. Depends on qrs_pkg.
module qrs_sqrt_cell
  import qrs_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  sq_t  d_in,
  output sq_t  d_out_r
);

  logic [SQR_W-1:0] rem_sh;
  logic [SQR_W-1:0] trial;
  sq_t              d_nxt;

  always_comb begin
    rem_sh = {d_in.rem[SQR_W-3:0], d_in.dsh[D_W-1 -: 2]};
    trial  = SQR_W'({d_in.root, 2'b01});
    d_nxt      = d_in;
    d_nxt.dsh  = {d_in.dsh[D_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      d_nxt.rem  = rem_sh - trial;
      d_nxt.root = {d_in.root[SQ_W-2:0], 1'b1};
    end else begin
      d_nxt.rem  = rem_sh;
      d_nxt.root = {d_in.root[SQ_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out_r <= d_nxt;
    end
  end

endmodule

[rtl/qrs_div_cell.sv]
// One cell of the divider row: a restoring step for both root numerators
// against the shared divisor |2a|. Depends on qrs_pkg.
module qrs_div_cell
  import qrs_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  dv_t  d_in,
  output dv_t  d_out_r
);

  logic [1:0][DR_W-1:0] rem_sh;
  dv_t                  d_nxt;

  always_comb begin
    d_nxt = d_in;
    for (int l = 0; l < 2; l++) begin
      rem_sh[l]   = {d_in.rem[l][DR_W-2:0], d_in.n[l][NUM_W-1]};
      d_nxt.n[l]  = {d_in.n[l][NUM_W-2:0], 1'b0};
      if (rem_sh[l] >= {1'b0, d_in.den_mag}) begin
        d_nxt.rem[l] = rem_sh[l] - {1'b0, d_in.den_mag};
        d_nxt.q[l]   = {d_in.q[l][NUM_W-2:0], 1'b1};
      end else begin
        d_nxt.rem[l] = rem_sh[l];
        d_nxt.q[l]   = {d_in.q[l][NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out_r <= d_nxt;
    end
  end

endmodule

[rtl/quadratic_root_solver.sv]
// Quadratic root solver top level: multiply and discriminant stages, a row
// of square-root cells, a row of divider cells and the output register.
// Depends on qrs_pkg, qrs_if, qrs_sqrt_cell and qrs_div_cell.
//
//  channel | dir | beat contents
//  --------+-----+-------------------------------------------
//  in_ch   | in  | coef_a, coef_b, coef_c (signed)
//  out_ch  | out | root_status, root_one, root_two (16 frac bits)
//
// One beat enters per cycle when the output is not stalled; a result passes
// through three front stages, 17 square-root cells, a numerator stage,
// 34 divider cells and the output register. Every stage holds its own valid
// bit and loads whenever it is empty or its successor loads, so bubbles
// close up under a stall. Reset clears the valid bits only.
module quadratic_root_solver
  import qrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  qrs_in_if.sink    in_ch,
  qrs_out_if.source out_ch
);

  localparam int S_SQ0 = 3;
  localparam int S_NUM = S_SQ0 + SQ_W;
  localparam int S_DV0 = S_NUM + 1;
  localparam int S_OUT = S_DV0 + NUM_W;
  localparam int NST   = S_OUT + 1;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] take;

  assign take[NST-1] = ~vld_r[NST-1] | out_ch.ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_take
    assign take[k] = ~vld_r[k] | take[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (take[0]) vld_r[0] <= in_ch.valid;
      for (int k = 1; k < NST; k++) begin
        if (take[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign in_ch.ready = take[0];

  // Input register.
  logic signed [COEF_W-1:0] a0_r, b0_r, c0_r;
  always_ff @(posedge clk) begin
    if (take[0]) begin
      a0_r <= in_ch.coef_a;
      b0_r <= in_ch.coef_b;
      c0_r <= in_ch.coef_c;
    end
  end

  // Products.
  logic [PROD_W-1:0]        bb1_r;
  logic signed [PROD_W-1:0] ac1_r;
  logic signed [COEF_W-1:0] a1_r, b1_r;
  always_ff @(posedge clk) begin
    if (take[1]) begin
      bb1_r <= PROD_W'(b0_r * b0_r);
      ac1_r <= a0_r * c0_r;
      a1_r  <= a0_r;
      b1_r  <= b0_r;
    end
  end

  // Discriminant and classification.
  logic signed [DISC_W-1:0] disc;
  logic [COEF_W-1:0]        amag;
  sq_t                      sq_nxt;
  sq_t                      sq_c [SQ_W+1];

  always_comb begin
    disc = $signed({3'b000, bb1_r}) - ($signed(DISC_W'(ac1_r)) <<< 2);
    amag = a1_r[COEF_W-1] ? COEF_W'(-a1_r) : COEF_W'(a1_r);
    sq_nxt.side.neg_b   = -$signed({b1_r[COEF_W-1], b1_r});
    sq_nxt.side.den_mag = {amag, 1'b0};
    sq_nxt.side.den_neg = a1_r[COEF_W-1];
    if (a1_r == '0) begin
      sq_nxt.side.status = ST_INVALID;
    end else if (disc[DISC_W-1]) begin
      sq_nxt.side.status = ST_IMAG;
    end else if (disc == '0) begin
      sq_nxt.side.status = ST_DOUBLE;
    end else begin
      sq_nxt.side.status = ST_TWO;
    end
    sq_nxt.rem  = '0;
    sq_nxt.root = '0;
    sq_nxt.dsh  = (sq_nxt.side.status == ST_TWO) ? disc[D_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (take[2]) begin
      sq_c[0] <= sq_nxt;
    end
  end

  for (genvar k = 0; k < SQ_W; k++) begin : g_sq
    qrs_sqrt_cell u_cell (
      .clk     (clk),
      .en      (take[S_SQ0+k]),
      .d_in    (sq_c[k]),
      .d_out_r (sq_c[k+1])
    );
  end

  // Numerators -b + s and -b - s, split into magnitude and quotient sign.
  side_t                 sd;
  logic signed [T_W-1:0] nb_x, s_x;
  logic signed [T_W-1:0] t [2];
  logic [T_W-2:0]        mag [2];
  dv_t                   dv_nxt;
  dv_t                   dv_c [NUM_W+1];

  always_comb begin
    sd   = sq_c[SQ_W].side;
    nb_x = T_W'(sd.neg_b);
    s_x  = $signed({2'b00, sq_c[SQ_W].root});
    unique case (sd.status)
      ST_TWO: begin
        t[0] = nb_x + s_x;
        t[1] = nb_x - s_x;
      end
      ST_DOUBLE: begin
        t[0] = nb_x;
        t[1] = '0;
      end
      default: begin
        t[0] = '0;
        t[1] = '0;
      end
    endcase
    dv_nxt.status  = sd.status;
    dv_nxt.den_mag = sd.den_mag;
    for (int l = 0; l < 2; l++) begin
      mag[l]        = t[l][T_W-1] ? (T_W-1)'(-t[l]) : (T_W-1)'(t[l]);
      dv_nxt.n[l]   = {mag[l], {FRAC_BITS{1'b0}}};
      dv_nxt.neg[l] = t[l][T_W-1] ^ sd.den_neg;
      dv_nxt.rem[l] = '0;
      dv_nxt.q[l]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (take[S_NUM]) begin
      dv_c[0] <= dv_nxt;
    end
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_dv
    qrs_div_cell u_cell (
      .clk     (clk),
      .en      (take[S_DV0+k]),
      .d_in    (dv_c[k]),
      .d_out_r (dv_c[k+1])
    );
  end

  // Output register: apply signs and zero the unused roots.
  dv_t                      dq;
  logic signed [ROOT_W-1:0] r_one_nxt, r_two_nxt;
  logic [1:0]               out_status_r;
  logic signed [ROOT_W-1:0] out_one_r, out_two_r;

  always_comb begin
    dq = dv_c[NUM_W];
    r_one_nxt = dq.neg[0] ? ROOT_W'(-dq.q[0]) : ROOT_W'(dq.q[0]);
    r_two_nxt = dq.neg[1] ? ROOT_W'(-dq.q[1]) : ROOT_W'(dq.q[1]);
    if (dq.status != ST_TWO && dq.status != ST_DOUBLE) begin
      r_one_nxt = '0;
    end
    if (dq.status != ST_TWO) begin
      r_two_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (take[S_OUT]) begin
      out_status_r <= dq.status;
      out_one_r    <= r_one_nxt;
      out_two_r    <= r_two_nxt;
    end
  end

  assign out_ch.valid       = vld_r[S_OUT];
  assign out_ch.root_status = out_status_r;
  assign out_ch.root_one    = out_one_r;
  assign out_ch.root_two    = out_two_r;

`ifndef SYNTHESIS
  a_two_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.root_status != ST_TWO |-> out_ch.root_two == '0)
    else $error("second root nonzero without two real roots");

  a_no_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.root_status == ST_IMAG || out_ch.root_status == ST_INVALID)
    |-> out_ch.root_one == '0)
    else $error("first root nonzero for imaginary or invalid result");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0] |-> in_ch.ready)
    else $error("input stage empty but not ready");
`endif

endmodule

[sim/quadratic_root_solver_tb_if.sv]
`timescale 1ns / 1ps
// Bench types: coefficient sets and expected roots. The channel interfaces
// come from rtl/qrs_if.sv. Depends on qrs_pkg. Holds nothing beyond this package.
package qrs_tb_pkg;
  import qrs_pkg::*;

  typedef struct {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
  } coef_set_t;

  typedef struct {
    status_t                  status;
    logic signed [ROOT_W-1:0] one;
    logic signed [ROOT_W-1:0] two;
  } roots_t;
endpackage

[sim/quadratic_root_solver_tb.sv]
`timescale 1ns / 1ps
// Testbench for quadratic_root_solver: streams coefficient beats, predicts
// each result with its own root model and checks every result beat.
// Depends on qrs_pkg, qrs_if, qrs_tb_pkg and the solver RTL.
module quadratic_root_solver_tb;
  import qrs_pkg::*;
  import qrs_tb_pkg::*;

  localparam int LATENCY = 56;

  logic clk;
  logic rst_n;
  qrs_in_if  in_ch ();
  qrs_out_if out_ch ();

  quadratic_root_solver i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  coef_set_t pending_sets[$];
  roots_t    expected_roots[$];
  int        idle_pct;
  int        stall_pct;
  int        errors;
  int        n_checked;
  int        status_seen[4];
  bit        in_took;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic [63:0] floor_sqrt(logic [65:0] d);
    logic [67:0] r;
    logic [67:0] t;
    r = '0;
    for (int bit_i = 33; bit_i >= 0; bit_i--) begin
      t = r | (68'd1 << bit_i);
      if (t * t <= {2'b00, d}) begin
        r = t;
      end
    end
    return r[63:0];
  endfunction

  function automatic logic signed [ROOT_W-1:0] fixed_quot(longint num, longint den);
    longint q;
    longint hi;
    hi = (longint'(1) << (ROOT_W - 1)) - 1;
    q = num / den;
    if (q > hi) begin
      q = hi;
    end
    if (q < -hi - 1) begin
      q = -hi - 1;
    end
    return q[ROOT_W-1:0];
  endfunction

  function automatic roots_t solve_roots(coef_set_t cs);
    roots_t           r;
    longint           a;
    longint           b;
    longint           c;
    logic signed [67:0] disc;
    longint           s;
    a = cs.a;
    b = cs.b;
    c = cs.c;
    r.status = ST_INVALID;
    r.one = '0;
    r.two = '0;
    if (a != 0) begin
      disc = 68'(b * b) - 68'(4 * a * c);
      if (disc < 0) begin
        r.status = ST_IMAG;
      end else if (disc == 0) begin
        r.status = ST_DOUBLE;
        r.one = fixed_quot(-b * (longint'(1) << FRAC_BITS), 2 * a);
      end else begin
        s = longint'(floor_sqrt(disc[65:0]));
        r.status = ST_TWO;
        r.one = fixed_quot((-b + s) * (longint'(1) << FRAC_BITS), 2 * a);
        r.two = fixed_quot((-b - s) * (longint'(1) << FRAC_BITS), 2 * a);
      end
    end
    return r;
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return COEF_W'($urandom_range(0, 7) - 4);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2: return COEF_W'($urandom_range(0, 255) - 128);
      default: return COEF_W'($urandom());
    endcase
  endfunction

  task automatic push_set(logic signed [COEF_W-1:0] a, logic signed [COEF_W-1:0] b,
                          logic signed [COEF_W-1:0] c);
    coef_set_t cs;
    cs.a = a;
    cs.b = b;
    cs.c = c;
    pending_sets.push_back(cs);
  endtask

  // Records whether the input beat was taken at the last rising edge.
  always @(posedge clk) begin
    in_took <= rst_n && in_ch.valid && in_ch.ready;
  end

  // Driver: presents the head of the queue, advancing on each accepted beat.
  // A beat that is waiting stays on the bus unchanged until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_took) begin
        void'(pending_sets.pop_front());
      end
      if (!(in_ch.valid && !in_took)) begin
        if (pending_sets.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          coef_set_t cs;
          cs = pending_sets[0];
          in_ch.valid  <= 1'b1;
          in_ch.coef_a <= cs.a;
          in_ch.coef_b <= cs.b;
          in_ch.coef_c <= cs.c;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor: predicts on each accepted coefficient beat, checks each result beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        coef_set_t cs;
        cs.a = in_ch.coef_a;
        cs.b = in_ch.coef_b;
        cs.c = in_ch.coef_c;
        expected_roots.push_back(solve_roots(cs));
      end
      if (out_ch.valid && out_ch.ready) begin
        roots_t want;
        if (expected_roots.size() == 0) begin
          $error("result beat with no expected result");
          errors++;
        end else begin
          want = expected_roots.pop_front();
          n_checked++;
          status_seen[want.status]++;
          if (out_ch.root_status !== want.status) begin
            $error("root_status: expected %0d, got %0d", want.status, out_ch.root_status);
            errors++;
          end
          if (out_ch.root_one !== want.one) begin
            $error("root_one: expected %0d, got %0d", want.one, out_ch.root_one);
            errors++;
          end
          if (out_ch.root_two !== want.two) begin
            $error("root_two: expected %0d, got %0d", want.two, out_ch.root_two);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int k;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.coef_a = '0;
    in_ch.coef_b = '0;
    in_ch.coef_c = '0;
    out_ch.ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    errors = 0;
    n_checked = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero a, imaginary, double root, two roots, field extremes.
    push_set(16'sd0, 16'sd5, 16'sd3);
    push_set(16'sd0, 16'sd0, 16'sd0);
    push_set(16'sd1, 16'sd0, 16'sd1);
    push_set(16'sd1, -16'sd2, 16'sd1);
    push_set(16'sd4, 16'sd4, 16'sd1);
    push_set(-16'sd1, 16'sd0, 16'sd0);
    push_set(16'sd1, -16'sd3, 16'sd2);
    push_set(16'sd1, 16'sd0, -16'sd1);
    push_set(16'sh8000, 16'sh8000, 16'sh7fff);
    push_set(16'sh8000, 16'sh7fff, 16'sh8000);
    push_set(16'sh7fff, 16'sh8000, 16'sh8000);
    push_set(16'sh7fff, 16'sh7fff, 16'sh7fff);
    push_set(16'sh8000, 16'sh8000, 16'sh8000);
    push_set(16'sd1, 16'sh8000, 16'sd0);
    push_set(-16'sd1, 16'sh7fff, 16'sh7fff);
    push_set(16'sd1, 16'sh8000, 16'sh4000);
    push_set(16'sh7fff, 16'sd0, 16'sh8000);
    push_set(-16'sd3, 16'sd7, -16'sd2);
    push_set(16'shffff, 16'shffff, 16'shffff);

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1) ? 66 : (phase == 3) ? 23 : 0;
      stall_pct = (phase == 2) ? 66 : (phase == 3) ? 23 : 0;
      for (int i = 0; i < 225; i++) begin
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] r;
        a = rand_coef();
        r = COEF_W'($urandom_range(0, 31) - 16);
        k = $urandom_range(0, 3);
        // Roughly a quarter are built as perfect squares to hit double roots.
        if (k == 0 && a != 0 && r >= -90 && r <= 90) begin
          b = COEF_W'(-2 * a * r);
          push_set(a, b, COEF_W'(a * r * r));
        end else begin
          push_set(a, rand_coef(), rand_coef());
        end
      end
      while (pending_sets.size() != 0) @(posedge clk);
    end
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("checked %0d results: %0d two-root, %0d double, %0d imaginary, %0d invalid",
             n_checked, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0 && expected_roots.size() == 0) begin
      $display("quadratic_root_solver verification clean");
    end else begin
      $display("quadratic_root_solver verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("quadratic_root_solver verification failed");
    $finish;
  end

endmodule
